[hdl/sstd_pkg.sv]
// Package for the sparse size table: sizes, entry layout, command codes,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sstd_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 20;
    localparam int SIZE_W  = 12;

    localparam logic [SIZE_W-1:0] RESET_DEFAULT_SIZE = 12'd25;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch the accepted transaction, rewind the scan
        logic advance;  // issue the next table read
        logic finish;   // commit result and table update
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic match;    // registered read entry holds the key
        logic miss;     // all valid entries scanned, no match
        logic out_free; // result register can take a new result
    } dp_status_t;

endpackage
`default_nettype wire

[hdl/sparse_size_table_with_default.sv]
// Sparse size table with default: a controller (sstd_ctrl) and a datapath
// (sstd_dpath) joined by command/status structs. Depends on sstd_pkg.
//
// Usage:
//   s_* channel: one transaction per item. s_cmd = lookup or set, s_row_index
//     is the key, s_new_size the size stored by a set.
//   m_* channel: one result per item: m_size_out, m_hit, m_dropped.
//   cfg_* channel: writes default_size (12 bits); cfg_ready is always high.
//     Write only while no item is in flight.
// Scan:
//   Stored entries are scanned in insertion order, one memory read per cycle
//   from a single-port entry memory with registered read data, up to all 64
//   entries of a full table. The scan stops at the first matching slot or
//   after the last stored entry; an empty table misses without a memory read.
//   The next item is accepted only after the previous one is committed.
//   The result register lets a new item be accepted and scanned while the
//   previous result still waits; a stalled receiver holds the next commit.
// Reset:
//   aresetn (synchronous, active low) empties the table (count to zero) and
//   sets default_size to 25. Memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sparse_size_table_with_default (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [sstd_pkg::KEY_W-1:0]    s_row_index,
    input  wire logic [sstd_pkg::SIZE_W-1:0]   s_new_size,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sstd_pkg::SIZE_W-1:0]        m_size_out,
    output logic                               m_hit,
    output logic                               m_dropped,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sstd_pkg::SIZE_W-1:0]   cfg_data
);

    sstd_pkg::ctrl_cmd_t  cmd;
    sstd_pkg::dp_status_t status;

    // sequencing: accept, scan, commit
    sstd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage, compare and result register
    sstd_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_cmd       (s_cmd),
        .s_row_index (s_row_index),
        .s_new_size  (s_new_size),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_size_out  (m_size_out),
        .m_hit       (m_hit),
        .m_dropped   (m_dropped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
`default_nettype wire

[hdl/sstd_ctrl.sv]
// Controller for the sparse size table: accepts a transaction, runs the scan,
// issues the commit. Depends on sstd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sstd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  sstd_pkg::dp_status_t    status,
    output sstd_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.start   = 1'b0;
        cmd.advance = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.match || status.miss) begin
                    // hold the scan until the result register frees up
                    if (status.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/sstd_dpath.sv]
// Datapath for the sparse size table: entry memory, scan pointer, entry count,
// default size register and result register. Depends on sstd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sstd_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_cmd,
    input  wire logic [sstd_pkg::KEY_W-1:0]    s_row_index,
    input  wire logic [sstd_pkg::SIZE_W-1:0]   s_new_size,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sstd_pkg::SIZE_W-1:0]        m_size_out,
    output logic                               m_hit,
    output logic                               m_dropped,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sstd_pkg::SIZE_W-1:0]   cfg_data,
    input  sstd_pkg::ctrl_cmd_t                cmd,
    output sstd_pkg::dp_status_t               status
);

    localparam logic [sstd_pkg::CNT_W-1:0] FULL = sstd_pkg::CNT_W'(sstd_pkg::ENTRIES);

    sstd_pkg::entry_t mem [sstd_pkg::ENTRIES];

    // transaction latched at accept
    logic                          op_reg;
    logic [sstd_pkg::KEY_W-1:0]    key_reg;
    logic [sstd_pkg::SIZE_W-1:0]   size_reg;

    logic [sstd_pkg::SIZE_W-1:0]   default_size_reg;
    logic [sstd_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sstd_pkg::CNT_W-1:0]    rd_addr_reg;
    logic                          q_vld_reg;
    logic [sstd_pkg::IDX_W-1:0]    q_idx_reg;
    sstd_pkg::entry_t              q_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [sstd_pkg::SIZE_W-1:0]   out_size_reg, out_size_next;
    logic                          out_hit_reg, out_hit_next;
    logic                          out_drop_reg, out_drop_next;

    logic                          rd_en;
    logic                          we;
    logic [sstd_pkg::IDX_W-1:0]    wr_addr;
    logic                          room;

    assign cfg_ready = 1'b1;
    assign room      = (count_reg != FULL);
    assign rd_en     = cmd.advance && (rd_addr_reg != count_reg);

    assign status.match    = q_vld_reg && (q_reg.key == key_reg);
    assign status.miss     = !q_vld_reg && (rd_addr_reg == count_reg);
    assign status.out_free = !out_valid_reg || m_ready;

    // result and table update
    always_comb begin
        out_size_next  = out_size_reg;
        out_hit_next   = out_hit_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && !m_ready;
        count_next     = count_reg;
        we             = 1'b0;
        wr_addr        = q_idx_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
            out_hit_next   = status.match;
            out_drop_next  = 1'b0;
            if (status.match) begin
                if (op_reg == sstd_pkg::CMD_SET) begin
                    we            = 1'b1;
                    out_size_next = size_reg;
                end else begin
                    out_size_next = q_reg.size;
                end
            end else if (op_reg == sstd_pkg::CMD_LOOKUP) begin
                out_size_next = default_size_reg;
            end else if (room) begin
                we            = 1'b1;
                wr_addr       = count_reg[sstd_pkg::IDX_W-1:0];
                count_next    = count_reg + 1'b1;
                out_size_next = size_reg;
            end else begin
                out_size_next = default_size_reg;
                out_drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q_reg <= mem[rd_addr_reg[sstd_pkg::IDX_W-1:0]];
        end
        if (we) begin
            mem[wr_addr] <= '{key: key_reg, size: size_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= s_cmd;
            key_reg  <= s_row_index;
            size_reg <= s_new_size;
        end
        if (rd_en) begin
            q_idx_reg <= rd_addr_reg[sstd_pkg::IDX_W-1:0];
        end
        out_size_reg <= out_size_next;
        out_hit_reg  <= out_hit_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_size_reg <= sstd_pkg::RESET_DEFAULT_SIZE;
            count_reg        <= '0;
            rd_addr_reg      <= '0;
            q_vld_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                default_size_reg <= cfg_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start) begin
                rd_addr_reg <= '0;
                q_vld_reg   <= 1'b0;
            end else if (cmd.advance) begin
                q_vld_reg <= rd_en;
                if (rd_en) begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_size_out = out_size_reg;
    assign m_hit      = out_hit_reg;
    assign m_dropped  = out_drop_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("entry count above capacity");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_drop_reg) |-> (!out_hit_reg && count_reg == FULL))
        else $error("drop flagged with room left or on a hit");

    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && status.miss && op_reg == sstd_pkg::CMD_SET && room)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the table");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("commit produced no result");
`endif

endmodule
`default_nettype wire
